>>> rtl/assert_macros.svh
// Assertion helpers used by the datapath module of the point counter.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define RPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define RPC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> rtl/rpc_pkg.sv
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared types and constants of the rectangle point counter.
// ----------------------------------------------------------------------------
`default_nettype none

package rpc_pkg;

  localparam int CountW = 9;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  typedef struct packed {
    logic clear;
    logic load;
    logic query;
    logic scan;
    logic result_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

>>> rtl/rpc_in_if.sv
// ----------------------------------------------------------------------------
// rpc_in_if
// Input channel: one operation beat with point and rectangle fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpc_in_if #(
  parameter int COORD_BITS = 21
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   op;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] x_low;
  logic signed [COORD_BITS-1:0] x_high;
  logic signed [COORD_BITS-1:0] y_low;
  logic signed [COORD_BITS-1:0] y_high;

  modport source (
    output valid, op, point_x, point_y, x_low, x_high, y_low, y_high,
    input  ready
  );

  modport sink (
    input  valid, op, point_x, point_y, x_low, x_high, y_low, y_high,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/rpc_out_if.sv
// ----------------------------------------------------------------------------
// rpc_out_if
// Result channel: one beat per rectangle query.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpc_out_if;
  logic                      valid;
  logic                      ready;
  logic [rpc_pkg::CountW-1:0] hit_count;
  logic                      points_dropped;

  modport source (
    output valid, hit_count, points_dropped,
    input  ready
  );

  modport sink (
    input  valid, hit_count, points_dropped,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/rpc_ctrl.sv
// ----------------------------------------------------------------------------
// rpc_ctrl
// Controller: decodes accepted beats and sequences the query scan.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire [1:0]            op_i,
  output logic                 in_ready_o,
  input  rpc_pkg::ctrl_sts_t   sts_i,
  output rpc_pkg::ctrl_cmd_t   cmd_o
);

  rpc_pkg::state_e state_q, state_d;
  rpc_pkg::op_e    op;

  assign op = rpc_pkg::op_e'(op_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      rpc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (op)
            rpc_pkg::OP_CLEAR: cmd_o.clear = 1'b1;
            rpc_pkg::OP_LOAD:  cmd_o.load  = 1'b1;
            rpc_pkg::OP_QUERY: begin
              cmd_o.query = 1'b1;
              state_d     = rpc_pkg::ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      rpc_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done && sts_i.out_free) begin
          cmd_o.result_load = 1'b1;
          state_d           = rpc_pkg::ST_IDLE;
        end
      end
      default: state_d = rpc_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/rpc_datapath.sv
// ----------------------------------------------------------------------------
// rpc_datapath
// Point store, scan address, bound compare, hit counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rpc_datapath #(
  parameter int MAX_POINTS = 256,
  parameter int COORD_BITS = 21
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  rpc_pkg::ctrl_cmd_t                 cmd_i,
  output rpc_pkg::ctrl_sts_t                 sts_o,
  input  wire signed [COORD_BITS-1:0]        point_x_i,
  input  wire signed [COORD_BITS-1:0]        point_y_i,
  input  wire signed [COORD_BITS-1:0]        x_low_i,
  input  wire signed [COORD_BITS-1:0]        x_high_i,
  input  wire signed [COORD_BITS-1:0]        y_low_i,
  input  wire signed [COORD_BITS-1:0]        y_high_i,
  input  wire                                out_ready_i,
  output logic                               out_valid_o,
  output logic [rpc_pkg::CountW-1:0]         hit_count_o,
  output logic                               points_dropped_o
);

  localparam int CntW  = $clog2(MAX_POINTS + 1);
  localparam int AddrW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  logic signed [COORD_BITS-1:0] mem_x [MAX_POINTS];
  logic signed [COORD_BITS-1:0] mem_y [MAX_POINTS];

  logic [CntW-1:0]              point_total_q;
  logic                         overflow_q;
  logic [CntW-1:0]              addr_q;
  logic [CntW-1:0]              hits_q;
  logic                         rd_vld_q;
  logic signed [COORD_BITS-1:0] rd_x_q, rd_y_q;
  logic signed [COORD_BITS-1:0] xl_q, xh_q, yl_q, yh_q;
  logic                         out_valid_q;
  logic [rpc_pkg::CountW-1:0]   hit_count_q;
  logic                         dropped_q;

  logic store_full;
  logic wr_en;
  logic rd_en;
  logic in_rect;

  assign store_full = (point_total_q >= CntW'(MAX_POINTS));
  assign wr_en      = cmd_i.load && !store_full;
  assign rd_en      = cmd_i.scan && (addr_q < point_total_q);
  assign in_rect    = (rd_x_q >= xl_q) && (rd_x_q <= xh_q) &&
                      (rd_y_q >= yl_q) && (rd_y_q <= yh_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x[point_total_q[AddrW-1:0]] <= point_x_i;
      mem_y[point_total_q[AddrW-1:0]] <= point_y_i;
    end
    if (rd_en) begin
      rd_x_q <= mem_x[addr_q[AddrW-1:0]];
      rd_y_q <= mem_y[addr_q[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.query) begin
      xl_q <= x_low_i;
      xh_q <= x_high_i;
      yl_q <= y_low_i;
      yh_q <= y_high_i;
    end
    if (cmd_i.result_load) begin
      hit_count_q <= rpc_pkg::CountW'(hits_q);
      dropped_q   <= overflow_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_total_q <= '0;
      overflow_q    <= 1'b0;
      addr_q        <= '0;
      hits_q        <= '0;
      rd_vld_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        point_total_q <= '0;
        overflow_q    <= 1'b0;
      end else if (cmd_i.load) begin
        if (store_full) begin
          overflow_q <= 1'b1;
        end else begin
          point_total_q <= point_total_q + 1'b1;
        end
      end

      if (cmd_i.query) begin
        addr_q   <= '0;
        hits_q   <= '0;
        rd_vld_q <= 1'b0;
      end else begin
        rd_vld_q <= rd_en;
        if (rd_en) begin
          addr_q <= addr_q + 1'b1;
        end
        if (rd_vld_q && in_rect) begin
          hits_q <= hits_q + 1'b1;
        end
      end

      if (cmd_i.result_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.scan_done  = (addr_q == point_total_q) && !rd_vld_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign hit_count_o      = hit_count_q;
  assign points_dropped_o = dropped_q;

  `RPC_ASSERT(a_total_bound, point_total_q <= CntW'(MAX_POINTS), "point count above capacity")
  `RPC_ASSERT(a_overflow_full, !overflow_q || store_full, "drop flag set with free entries")
  `RPC_ASSERT(a_scan_addr, !cmd_i.scan || (addr_q <= point_total_q), "scan address past fill level")
  `RPC_ASSERT_NEVER(a_scan_total, cmd_i.scan && $past(cmd_i.scan) && !$stable(point_total_q), "fill level moved during scan")

endmodule

`default_nettype wire

>>> rtl/rect_point_count.sv
// ----------------------------------------------------------------------------
// rect_point_count: counts stored points inside an inclusive rectangle.
// Clear and load give no result beat.
// A query scans the stored points in order through the read of the point
// store and its compare stage, and its result beat is loaded once the scan
// is done and the output register is free; one operation at a time.
// Reset empties the store and clears the drop flag; entries need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module rect_point_count #(
  parameter int MAX_POINTS = 256,
  parameter int COORD_BITS = 21
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  rpc_in_if.sink    in_i,
  rpc_out_if.source out_o
);

  rpc_pkg::ctrl_cmd_t cmd;
  rpc_pkg::ctrl_sts_t sts;

  rpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .op_i       (in_i.op),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rpc_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .point_x_i        (in_i.point_x),
    .point_y_i        (in_i.point_y),
    .x_low_i          (in_i.x_low),
    .x_high_i         (in_i.x_high),
    .y_low_i          (in_i.y_low),
    .y_high_i         (in_i.y_high),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .hit_count_o      (out_o.hit_count),
    .points_dropped_o (out_o.points_dropped)
  );

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of rect_point_count
// Drives clear, load and rectangle query beats through the input channel and
// keeps its own copy of the point store to predict every query result. Each
// result beat is compared with the oldest prediction. The sender works in
// bursts with random gaps, and the receiver stalls on a changing bit pattern.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int CoordBits = 21;
  localparam int MaxPoints = 256;
  localparam int RandomBeats = 700;
  localparam logic [1:0] OpUnused = 2'd3;

  typedef logic signed [CoordBits-1:0] coord_t;

  localparam coord_t CoordMax = {1'b0, {(CoordBits - 1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(CoordBits - 1){1'b0}}};

  typedef struct packed {
    logic [rpc_pkg::CountW-1:0] hit_count;
    logic                       points_dropped;
  } tally_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rpc_in_if #(.COORD_BITS(CoordBits)) in_bus ();
  rpc_out_if out_bus ();

  rect_point_count #(
    .MAX_POINTS(MaxPoints),
    .COORD_BITS(CoordBits)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus.sink),
    .out_o (out_bus.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the point store.
  coord_t shadow_x [MaxPoints];
  coord_t shadow_y [MaxPoints];
  int     shadow_total;
  logic   shadow_dropped;

  tally_t expected_tallies [$];
  int     err_count;
  int     burst_left;

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= 100) begin
      $display("ERROR at %0t: %s, got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // Applies one accepted beat to the shadow store and queues the expected result of a query.
  task automatic account_beat(input logic [1:0] op, input coord_t px, input coord_t py,
                              input coord_t xl, input coord_t xh,
                              input coord_t yl, input coord_t yh);
    tally_t t;
    int hits;
    hits = 0;
    case (op)
      rpc_pkg::OP_CLEAR: begin
        shadow_total = 0;
        shadow_dropped = 1'b0;
      end
      rpc_pkg::OP_LOAD: begin
        if (shadow_total < MaxPoints) begin
          shadow_x[shadow_total] = px;
          shadow_y[shadow_total] = py;
          shadow_total++;
        end else begin
          shadow_dropped = 1'b1;
        end
      end
      rpc_pkg::OP_QUERY: begin
        for (int i = 0; i < shadow_total; i++) begin
          if (shadow_x[i] >= xl && shadow_x[i] <= xh &&
              shadow_y[i] >= yl && shadow_y[i] <= yh) begin
            hits++;
          end
        end
        t.hit_count = hits[rpc_pkg::CountW-1:0];
        t.points_dropped = shadow_dropped;
        expected_tallies.push_back(t);
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_beat(input logic [1:0] op, input coord_t px, input coord_t py,
                           input coord_t xl, input coord_t xh,
                           input coord_t yl, input coord_t yh);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_bus.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    in_bus.valid   = 1'b1;
    in_bus.op      = op;
    in_bus.point_x = px;
    in_bus.point_y = py;
    in_bus.x_low   = xl;
    in_bus.x_high  = xh;
    in_bus.y_low   = yl;
    in_bus.y_high  = yh;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    burst_left--;
    account_beat(op, px, py, xl, xh, yl, yh);
  endtask

  function automatic coord_t junk();
    return coord_t'($urandom);
  endfunction

  function automatic coord_t near_zero();
    return coord_t'(int'($urandom_range(0, 127)) - 64);
  endfunction

  task automatic send_load(input coord_t px, input coord_t py);
    send_beat(rpc_pkg::OP_LOAD, px, py, junk(), junk(), junk(), junk());
  endtask

  task automatic send_query(input coord_t xl, input coord_t xh,
                            input coord_t yl, input coord_t yh);
    send_beat(rpc_pkg::OP_QUERY, junk(), junk(), xl, xh, yl, yh);
  endtask

  task automatic send_other(input logic [1:0] op);
    send_beat(op, junk(), junk(), junk(), junk(), junk(), junk());
  endtask

  task automatic pick_point(input bit clustered, output coord_t px, output coord_t py);
    int idx;
    if (shadow_total > 0 && $urandom_range(0, 7) == 0) begin
      idx = $urandom_range(0, shadow_total - 1);
      px = shadow_x[idx];
      py = shadow_y[idx];
    end else if (clustered) begin
      px = near_zero();
      py = near_zero();
    end else begin
      px = junk();
      py = junk();
    end
  endtask

  task automatic pick_rect(output coord_t xl, output coord_t xh,
                           output coord_t yl, output coord_t yh);
    int mode;
    int idx;
    mode = $urandom_range(0, 9);
    if (mode <= 3 && shadow_total > 0) begin
      idx = $urandom_range(0, shadow_total - 1);
      xl = shadow_x[idx] - coord_t'($urandom_range(0, 40));
      xh = shadow_x[idx] + coord_t'($urandom_range(0, 40));
      yl = shadow_y[idx] - coord_t'($urandom_range(0, 40));
      yh = shadow_y[idx] + coord_t'($urandom_range(0, 40));
    end else if (mode <= 5) begin
      xl = near_zero();
      xh = xl + coord_t'($urandom_range(0, 80));
      yl = near_zero();
      yh = yl + coord_t'($urandom_range(0, 80));
    end else if (mode == 6) begin
      xl = CoordMin;
      xh = CoordMax;
      yl = CoordMin;
      yh = CoordMax;
    end else if (mode == 7) begin
      xl = junk();
      xh = junk();
      yl = junk();
      yh = junk();
    end else if (mode == 8) begin
      xh = near_zero();
      xl = xh + coord_t'($urandom_range(1, 40));
      yl = near_zero();
      yh = yl + coord_t'($urandom_range(0, 80));
      if ($urandom_range(0, 1) == 1) begin
        {xl, xh, yl, yh} = {yl, yh, xl, xh};
      end
    end else begin
      xl = junk();
      xh = junk();
      yl = CoordMin;
      yh = CoordMax;
      if ($urandom_range(0, 1) == 1) begin
        {xl, xh, yl, yh} = {yl, yh, xl, xh};
      end
    end
  endtask

  task automatic test_empty_store();
    send_query(CoordMin, CoordMax, CoordMin, CoordMax);
    send_other(OpUnused);
    send_query(CoordMin, CoordMax, CoordMin, CoordMax);
  endtask

  task automatic test_extreme_points();
    send_other(rpc_pkg::OP_CLEAR);
    send_load(CoordMin, CoordMin);
    send_load(CoordMax, CoordMax);
    send_load(CoordMin, CoordMax);
    send_load(CoordMax, CoordMin);
    send_load('0, '0);
    send_load('0, '0);
    send_query(CoordMin, CoordMax, CoordMin, CoordMax);
    send_query('0, '0, '0, '0);
    send_query(CoordMax, CoordMax, CoordMax, CoordMax);
    send_query(CoordMin, CoordMin, CoordMin, CoordMax);
    send_query(coord_t'(1), CoordMax, CoordMin, coord_t'(-1));
  endtask

  task automatic test_inverted_rects();
    send_query(coord_t'(1), '0, CoordMin, CoordMax);
    send_query(CoordMin, CoordMax, CoordMax, CoordMin);
    send_query(CoordMax, CoordMin, CoordMax, CoordMin);
    send_other(OpUnused);
    send_query(CoordMin, CoordMax, CoordMin, CoordMax);
  endtask

  task automatic test_full_store();
    coord_t px, py, xl, xh, yl, yh;
    send_other(rpc_pkg::OP_CLEAR);
    for (int i = 0; i < MaxPoints; i++) begin
      pick_point(1'b1, px, py);
      send_load(px, py);
    end
    send_query(CoordMin, CoordMax, CoordMin, CoordMax);
    repeat (2) begin
      pick_rect(xl, xh, yl, yh);
      send_query(xl, xh, yl, yh);
    end
    repeat (2) begin
      pick_point(1'b1, px, py);
      send_load(px, py);
    end
    send_query(CoordMin, CoordMax, CoordMin, CoordMax);
    repeat (2) begin
      pick_rect(xl, xh, yl, yh);
      send_query(xl, xh, yl, yh);
    end
    send_other(rpc_pkg::OP_CLEAR);
    send_query(CoordMin, CoordMax, CoordMin, CoordMax);
  endtask

  task automatic test_random_sequences(input int beat_goal);
    coord_t px, py, xl, xh, yl, yh;
    int sent;
    int seq_len;
    int pick;
    bit clustered;
    sent = 0;
    while (sent < beat_goal) begin
      clustered = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) != 0) begin
        send_other(rpc_pkg::OP_CLEAR);
        sent++;
      end
      seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70) : $urandom_range(3, 20);
      repeat (seq_len) begin
        pick = $urandom_range(0, 19);
        if (pick < 11) begin
          pick_point(clustered, px, py);
          send_load(px, py);
          sent++;
        end else if (pick < 19) begin
          pick_rect(xl, xh, yl, yh);
          send_query(xl, xh, yl, yh);
          sent++;
        end else begin
          send_other(OpUnused);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    tally_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_tallies.size() == 0) begin
        report_mismatch("result beat with no query pending", out_bus.hit_count, 0);
      end else begin
        want = expected_tallies.pop_front();
        if (out_bus.hit_count !== want.hit_count) begin
          report_mismatch("hit_count", out_bus.hit_count, want.hit_count);
        end
        if (out_bus.points_dropped !== want.points_dropped) begin
          report_mismatch("points_dropped", out_bus.points_dropped, want.points_dropped);
        end
      end
    end
  end

  initial begin
    logic [15:0] stall_pat;
    int pat_age;
    int pat_bit;
    out_bus.ready = 1'b0;
    stall_pat = '1;
    pat_age = 0;
    pat_bit = 0;
    forever begin
      @(negedge clk_i);
      if (pat_age == 0) begin
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
        pat_age = $urandom_range(16, 96);
      end
      pat_age--;
      pat_bit = (pat_bit + 1) % 16;
      out_bus.ready = rst_ni && stall_pat[pat_bit];
    end
  end

  initial begin
    #20_000_000;
    $display("rect_point_count: mismatch");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.op = rpc_pkg::OP_CLEAR;
    in_bus.point_x = '0;
    in_bus.point_y = '0;
    in_bus.x_low = '0;
    in_bus.x_high = '0;
    in_bus.y_low = '0;
    in_bus.y_high = '0;
    shadow_total = 0;
    shadow_dropped = 1'b0;
    err_count = 0;
    burst_left = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_store();
    test_extreme_points();
    test_inverted_rects();
    test_full_store();
    test_random_sequences(RandomBeats - MaxPoints - 12);

    @(negedge clk_i);
    in_bus.valid = 1'b0;
    while (expected_tallies.size() != 0) @(posedge clk_i);
    repeat (MaxPoints + 16) @(posedge clk_i);

    if (err_count == 0) begin
      $display("rect_point_count: match");
    end else begin
      $display("rect_point_count: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/rpc_pkg.sv
rtl/rpc_in_if.sv
rtl/rpc_out_if.sv
rtl/rpc_ctrl.sv
rtl/rpc_datapath.sv
rtl/rect_point_count.sv
bench/tb_top.sv
